// ----- rtl/core/lsfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder package
// Request/result types, controller states and the three-bit line encoding.
// ----------------------------------------------------------------------------
package lsfe_pkg;

  localparam int NUM_PIXELS_W = 9;

  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] LAST_BYTE = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] first_led;
    logic [7:0] last_led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lsfe_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] spi_byte;
    logic       frame_last;
  } lsfe_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ
  } lsfe_state_t;

  typedef enum logic [1:0] {
    COL_GREEN,
    COL_RED,
    COL_BLUE
  } lsfe_col_t;

  // One byte of the line stream: color channel col of pixel grb, byte bsel
  // of its 24 line bits (high byte first). One bit -> 110, zero bit -> 100.
  function automatic logic [7:0] encode_byte(logic [23:0] grb, lsfe_col_t col,
                                             logic [1:0] bsel);
    logic [7:0]  c;
    logic [23:0] line;
    logic [7:0]  b;
    case (col)
      COL_GREEN: c = grb[23:16];
      COL_RED:   c = grb[15:8];
      default:   c = grb[7:0];
    endcase
    for (int i = 0; i < 8; i++) begin
      line[3*i +: 3] = {1'b1, c[i], 1'b0};
    end
    case (bsel)
      2'd0:    b = line[23:16];
      2'd1:    b = line[15:8];
      default: b = line[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/lsfe_pixel_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color store
// One-write, one-read synchronous RAM of 24-bit GRB colors with a clearing
// pass after reset that blackens every entry, one per cycle.
// ----------------------------------------------------------------------------
module lsfe_pixel_ram #(
  parameter int MAX_LEDS = 256,
  parameter int ADDR_W   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [23:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [23:0]       rdata,
  output logic              ready
);

  logic [23:0]       mem [MAX_LEDS];
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(MAX_LEDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign ready = !clearing;

endmodule

// ----- rtl/core/lsfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder controller
// Accepts requests, walks fill ranges into the store and steps the frame
// read pointer (header byte, pixel, color channel, line byte).
// ----------------------------------------------------------------------------
module lsfe_ctrl #(
  parameter int ADDR_W = 8,
  parameter int N_W    = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lsfe_pkg::lsfe_req_t request,
  input  logic [N_W-1:0]      n,
  input  logic                ram_ready,
  input  logic [23:0]         rdata,
  output logic                busy,
  output logic                done,
  output lsfe_pkg::lsfe_rsp_t result,
  output logic                we,
  output logic [ADDR_W-1:0]   waddr,
  output logic [23:0]         wdata,
  output logic [ADDR_W-1:0]   raddr
);

  lsfe_pkg::lsfe_state_t state, state_next;
  lsfe_pkg::lsfe_req_t   req;
  lsfe_pkg::lsfe_col_t   col;
  logic [7:0]            fill_idx;
  logic                  hdr;
  logic [ADDR_W-1:0]     pix;
  logic [1:0]            bsel;

  logic accept;
  logic reject;
  logic restart;
  logic pix_last;

  assign accept   = start && !busy;
  assign reject   = (request.first_led > request.last_led) ||
                    (N_W'(request.last_led) >= n);
  // pointer at the header or past a shrunk frame: emit the leading zero byte
  assign restart  = hdr || (N_W'(pix) >= n);
  assign pix_last = (N_W'(pix) + N_W'(1) == n) && (col == lsfe_pkg::COL_BLUE) &&
                    (bsel == lsfe_pkg::LAST_BYTE);

  always_comb begin
    state_next = state;
    unique case (state)
      lsfe_pkg::ST_IDLE: begin
        if (accept) begin
          if (request.req_type == lsfe_pkg::REQ_FILL) begin
            if (!reject) state_next = lsfe_pkg::ST_FILL;
          end else if (!restart) begin
            state_next = lsfe_pkg::ST_READ;
          end
        end
      end
      lsfe_pkg::ST_FILL: begin
        if (fill_idx == req.last_led) state_next = lsfe_pkg::ST_IDLE;
      end
      lsfe_pkg::ST_READ: state_next = lsfe_pkg::ST_IDLE;
      default:           state_next = lsfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != lsfe_pkg::ST_IDLE) || !ram_ready;
    we    = (state == lsfe_pkg::ST_FILL);
    waddr = ADDR_W'(fill_idx);
    wdata = {req.green, req.red, req.blue};
    raddr = pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsfe_pkg::ST_IDLE;
      done  <= 1'b0;
      hdr   <= 1'b1;
      pix   <= '0;
      col   <= lsfe_pkg::COL_GREEN;
      bsel  <= 2'd0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        lsfe_pkg::ST_IDLE: begin
          if (accept) begin
            req      <= request;
            fill_idx <= request.first_led;
            if (request.req_type == lsfe_pkg::REQ_FILL) begin
              if (reject) begin
                done   <= 1'b1;
                result <= '{status: 1'b1, spi_byte: 8'h00, frame_last: 1'b0};
              end
            end else if (restart) begin
              done   <= 1'b1;
              result <= '{status: 1'b0, spi_byte: 8'h00, frame_last: (n == '0)};
              hdr    <= (n == '0);
              pix    <= '0;
              col    <= lsfe_pkg::COL_GREEN;
              bsel   <= 2'd0;
            end
          end
        end
        lsfe_pkg::ST_FILL: begin
          fill_idx <= fill_idx + 8'd1;
          if (fill_idx == req.last_led) begin
            done   <= 1'b1;
            result <= '{status: 1'b0, spi_byte: 8'h00, frame_last: 1'b0};
          end
        end
        lsfe_pkg::ST_READ: begin
          done   <= 1'b1;
          result <= '{status: 1'b0,
                      spi_byte: lsfe_pkg::encode_byte(rdata, col, bsel),
                      frame_last: pix_last};
          if (pix_last) begin
            hdr <= 1'b1;
          end else if (bsel == lsfe_pkg::LAST_BYTE) begin
            bsel <= 2'd0;
            case (col)
              lsfe_pkg::COL_GREEN: col <= lsfe_pkg::COL_RED;
              lsfe_pkg::COL_RED:   col <= lsfe_pkg::COL_BLUE;
              default: begin
                col <= lsfe_pkg::COL_GREEN;
                pix <= pix + 1'b1;
              end
            endcase
          end else begin
            bsel <= bsel + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/led_strip_frame_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder
// Pixel color store feeding the three-bit-per-bit SPI stream of an
// addressable LED strip.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows
// for one cycle with done and cannot be held off. A read tick reads the RAM
// as it is taken in IDLE, then gives the encoded byte from READ; the leading
// zero byte of a frame is given straight from IDLE. A fill of first..last
// makes one RAM write per pixel in FILL; a rejected fill answers straight
// from IDLE. After reset the store is cleared to black, one pixel per cycle,
// so busy stays high until that pass ends; num_pixels writes are taken meanwhile.
module led_strip_frame_encoder #(
  parameter int MAX_LEDS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lsfe_pkg::lsfe_req_t request,
  output logic                done,
  output lsfe_pkg::lsfe_rsp_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [lsfe_pkg::NUM_PIXELS_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W  = $clog2(MAX_LEDS + 1);
  localparam int N_W    = (CNT_W > lsfe_pkg::NUM_PIXELS_W) ? CNT_W : lsfe_pkg::NUM_PIXELS_W;

  logic [lsfe_pkg::NUM_PIXELS_W-1:0] num_pixels;
  logic [N_W-1:0]                    np_ext;
  logic [N_W-1:0]                    n;

  logic              ram_ready;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [23:0]       wdata;
  logic [23:0]       rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_pixels <= '0;
    end else if (cfg_valid && cfg_ready) begin
      num_pixels <= cfg_data;
    end
  end

  // pixels in use, saturated at the store depth
  assign np_ext = N_W'(num_pixels);
  assign n      = (np_ext > N_W'(MAX_LEDS)) ? N_W'(MAX_LEDS) : np_ext;

  lsfe_pixel_ram #(
    .MAX_LEDS (MAX_LEDS),
    .ADDR_W   (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata),
    .ready (ram_ready)
  );

  lsfe_ctrl #(
    .ADDR_W (ADDR_W),
    .N_W    (N_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .n         (n),
    .ram_ready (ram_ready),
    .rdata     (rdata),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr)
  );

endmodule

// ----- dv/lsfe_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder response checker
// Keeps its own copy of the pixel store, frame pointer and pixel count,
// predicts the response of every request taken by the block and compares it
// field by field with the response marked by done.
// ----------------------------------------------------------------------------
module lsfe_frame_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  lsfe_pkg::lsfe_req_t               request,
  input  logic                              done,
  input  lsfe_pkg::lsfe_rsp_t               result,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [lsfe_pkg::NUM_PIXELS_W-1:0] cfg_data,
  output int                                fail_count,
  output int                                pending
);

  localparam int unsigned STRIP_MAX     = 256;
  localparam int unsigned BYTES_PER_LED = 9;

  logic [23:0]                       grb_store [STRIP_MAX];
  logic [11:0]                       frame_ptr;
  logic [lsfe_pkg::NUM_PIXELS_W-1:0] strip_len;
  lsfe_pkg::lsfe_rsp_t               rsp_due [$];

  // 8 color bits -> 24 line bits, MSB first, 110 for one, 100 for zero
  function automatic logic [23:0] line_code(input logic [7:0] c);
    logic [23:0] w;
    w = '0;
    for (int i = 7; i >= 0; i--) w = {w[20:0], 1'b1, c[i], 1'b0};
    return w;
  endfunction

  function automatic int unsigned active_leds();
    return (strip_len > STRIP_MAX) ? STRIP_MAX : 32'(strip_len);
  endfunction

  // byte p of the frame: leading zero, then G, R, B line codes per pixel
  function automatic logic [7:0] stream_byte(input int unsigned p);
    int unsigned q;
    logic [7:0]  c;
    logic [23:0] code;
    if (p == 0) return 8'h00;
    q    = p - 1;
    c    = 8'(grb_store[q / BYTES_PER_LED] >> (16 - 8 * ((q % BYTES_PER_LED) / 3)));
    code = line_code(c);
    return 8'(code >> (8 * (2 - (q % 3))));
  endfunction

  function automatic lsfe_pkg::lsfe_rsp_t apply_request(input lsfe_pkg::lsfe_req_t r);
    lsfe_pkg::lsfe_rsp_t rsp;
    int unsigned         n;
    int unsigned         len;
    n   = active_leds();
    rsp = '0;
    if (r.req_type == lsfe_pkg::REQ_FILL) begin
      if (r.first_led > r.last_led || r.last_led >= n) begin
        rsp.status = 1'b1;
      end else begin
        for (int i = r.first_led; i <= r.last_led; i++)
          grb_store[i] = {r.green, r.red, r.blue};
      end
    end else begin
      len = n * BYTES_PER_LED + 1;
      // pixel count shrunk under the pointer: frame restarts
      if (frame_ptr >= len) frame_ptr = '0;
      rsp.spi_byte   = stream_byte(32'(frame_ptr));
      rsp.frame_last = (frame_ptr == len - 1);
      frame_ptr      = rsp.frame_last ? 12'd0 : frame_ptr + 12'd1;
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    lsfe_pkg::lsfe_rsp_t want;
    if (rst) begin
      foreach (grb_store[i]) grb_store[i] = '0;
      frame_ptr = '0;
      strip_len = '0;
      rsp_due.delete();
    end else begin
      if (done) begin
        if (rsp_due.size() == 0) begin
          fail_count++;
          $display("%0t: response with none pending: status=%0d byte=%02h last=%0d",
                   $realtime, result.status, result.spi_byte, result.frame_last);
        end else begin
          want = rsp_due.pop_front();
          if (result.status !== want.status || result.spi_byte !== want.spi_byte ||
              result.frame_last !== want.frame_last) begin
            fail_count++;
            $display({"%0t: mismatch: expected status=%0d byte=%02h last=%0d, ",
                      "got status=%0d byte=%02h last=%0d"},
                     $realtime, want.status, want.spi_byte, want.frame_last,
                     result.status, result.spi_byte, result.frame_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) strip_len = cfg_data;
      if (start && !busy) rsp_due.push_back(apply_request(request));
    end
    pending = rsp_due.size();
  end

endmodule

// ----- dv/led_strip_frame_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame encoder testbench
// Drives fill and read-tick requests plus pixel count writes through several
// sender idle patterns; the response checker predicts and compares.
// ----------------------------------------------------------------------------
module led_strip_frame_encoder_tb;

  localparam int REQ_W = $bits(lsfe_pkg::lsfe_req_t);
  localparam int NP_W  = lsfe_pkg::NUM_PIXELS_W;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  lsfe_pkg::lsfe_req_t request   = '0;
  logic                cfg_valid = 1'b0;
  logic [NP_W-1:0]     cfg_data  = '0;
  logic                busy;
  logic                done;
  lsfe_pkg::lsfe_rsp_t result;
  logic                cfg_ready;
  int                  fail_count;
  int                  pending;

  int          idle_pct    = 0;
  int unsigned leds_in_use = 0;

  int unsigned phase_leds [6] = '{5, 256, 2, 511, 9, 1};
  int          phase_idle [6] = '{0, 88, 17, 0, 88, 17};

  always #1 clk = ~clk;

  led_strip_frame_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lsfe_frame_checker frame_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // idle cycles carry junk on the request bus
  task automatic sender_idle();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start   = 1'b0;
      request = REQ_W'({$urandom, $urandom});
    end
  endtask

  task automatic issue(input lsfe_pkg::lsfe_req_t r);
    sender_idle();
    @(negedge clk);
    start   = 1'b1;
    request = r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic fill(input logic [7:0] f, l, r, g, b);
    lsfe_pkg::lsfe_req_t q;
    q           = '0;
    q.req_type  = lsfe_pkg::REQ_FILL;
    q.first_led = f;
    q.last_led  = l;
    q.red       = r;
    q.green     = g;
    q.blue      = b;
    issue(q);
  endtask

  task automatic read_tick();
    lsfe_pkg::lsfe_req_t q;
    q          = REQ_W'({$urandom, $urandom});
    q.req_type = lsfe_pkg::REQ_READ;
    issue(q);
  endtask

  // every request gives a response, so no pending and not busy means idle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic set_leds(input int unsigned v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = NP_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid   = 1'b0;
    leds_in_use = (v > 256) ? 256 : v;
  endtask

  // mostly read ticks, else mostly legal fills over short ranges; the rest is raw noise
  task automatic random_item();
    int unsigned f;
    int unsigned l;
    int unsigned span;
    if ($urandom_range(9) < 6) begin
      read_tick();
    end else if (leds_in_use != 0 && $urandom_range(9) < 8) begin
      f    = $urandom_range(leds_in_use - 1);
      span = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(7);
      l    = f + span;
      if (l >= leds_in_use) l = leds_in_use - 1;
      fill(8'(f), 8'(l), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      fill(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // empty strip: fills rejected, frame is the lone zero byte
    fill(8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    fill(8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    read_tick();
    read_tick();

    set_leds(2);
    fill(8'd0, 8'd1, 8'hFF, 8'h00, 8'hAA);
    fill(8'd1, 8'd1, 8'h00, 8'hFF, 8'h55);
    fill(8'd1, 8'd0, 8'h12, 8'h34, 8'h56);
    fill(8'd0, 8'd2, 8'h12, 8'h34, 8'h56);
    repeat (9) read_tick();

    // oversized count saturates to the full strip
    set_leds(511);
    read_tick();
    fill(8'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    fill(8'd255, 8'd255, 8'h00, 8'h00, 8'h00);
    fill(8'd200, 8'd100, 8'hFF, 8'hFF, 8'hFF);
    read_tick();

    // shrink under the pointer: frame restarts
    set_leds(0);
    read_tick();

    for (int p = 0; p < 6; p++) begin
      set_leds(phase_leds[p]);
      idle_pct = phase_idle[p];
      repeat (128) random_item();
      set_leds($urandom_range(12));
      repeat (128) random_item();
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- led_strip_frame_encoder.f -----
rtl/core/lsfe_pkg.sv
rtl/core/lsfe_pixel_ram.sv
rtl/core/lsfe_ctrl.sv
rtl/core/led_strip_frame_encoder.sv
dv/lsfe_frame_checker.sv
dv/led_strip_frame_encoder_tb.sv
